[rtl/slpg_pkg.sv]
// shared types, constants and tables for the status led pattern generator
package slpg_pkg;

  localparam int unsigned NUM_STATUS = 7;
  localparam int unsigned PHASE_MOD  = 70;
  localparam int unsigned PHASE_W    = 7;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned REM_W      = 21;
  localparam int unsigned QUO_W      = 12;
  localparam int unsigned STEP_W     = 4;
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 32;

  // input kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_FLASH  = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;
  localparam logic [1:0] KIND_READY  = 2'd3;

  // register indexes
  localparam logic [1:0] REG_RED_EN   = 2'd0;
  localparam logic [1:0] REG_GREEN_EN = 2'd1;
  localparam logic [1:0] REG_BLUE_EN  = 2'd2;

  // divisors for the pulse path
  localparam logic [REM_W-1:0] DIV_PERIOD_US = 21'd2000000;
  localparam logic [REM_W-1:0] DIV_THOUSAND  = 21'd1000;
  localparam logic [REM_W-1:0] DIV_FULL      = 21'd255;

  // divider steps (4 bits each) per operation
  localparam logic [STEP_W-1:0] STEPS_PERIOD = 4'd12;
  localparam logic [STEP_W-1:0] STEPS_MS     = 4'd6;
  localparam logic [STEP_W-1:0] STEPS_BRIGHT = 4'd5;
  localparam logic [STEP_W-1:0] STEPS_SCALE  = 4'd4;

  localparam logic [10:0] HALF_PERIOD_MS = 11'd1000;
  localparam logic [10:0] FULL_PERIOD_MS = 11'd2000;

  typedef enum logic [2:0] {
    PAT_STEADY,
    PAT_B1,
    PAT_B4,
    PAT_DBL,
    PAT_BREATHE
  } pat_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FLASH,
    ST_CHECK,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    OP_PERIOD,
    OP_MS,
    OP_BRIGHT,
    OP_RED,
    OP_GREEN
  } div_op_e;

  typedef struct packed {
    logic [DUTY_W-1:0] r;
    logic [DUTY_W-1:0] g;
    pat_e              pat;
  } status_t;

  typedef struct packed {
    logic red_en;
    logic green_en;
    logic blue_en;
  } cfg_t;

  typedef struct packed {
    logic              red_write;
    logic [DUTY_W-1:0] red_duty;
    logic              green_write;
    logic [DUTY_W-1:0] green_duty;
    logic              blue_write;
    logic [DUTY_W-1:0] blue_duty;
  } result_t;

  typedef struct packed {
    logic              start;
    logic [TIME_W-1:0] dividend;
    logic [REM_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
    logic [REM_W-1:0] rem;
  } div_rsp_t;

  function automatic status_t status_lookup(logic [2:0] code);
    status_t e;
    unique case (code)
      3'd0:    e = '{r: 8'd60,  g: 8'd60,  pat: PAT_BREATHE};
      3'd1:    e = '{r: 8'd255, g: 8'd0,   pat: PAT_B1};
      3'd2:    e = '{r: 8'd0,   g: 8'd255, pat: PAT_STEADY};
      3'd3:    e = '{r: 8'd255, g: 8'd180, pat: PAT_BREATHE};
      3'd4:    e = '{r: 8'd255, g: 8'd0,   pat: PAT_DBL};
      3'd5:    e = '{r: 8'd255, g: 8'd120, pat: PAT_B4};
      3'd6:    e = '{r: 8'd255, g: 8'd0,   pat: PAT_B4};
      default: e = '{r: 8'd60,  g: 8'd60,  pat: PAT_BREATHE};
    endcase
    return e;
  endfunction

  // on/off per tick phase
  function automatic logic [PHASE_MOD-1:0] pattern_mask(pat_e p);
    logic [PHASE_MOD-1:0] m;
    m = '0;
    for (int i = 0; i < PHASE_MOD; i++) begin
      unique case (p)
        PAT_B1:  m[i] = ((i % 10) < 5);
        PAT_B4:  m[i] = ((i % 5) == 0) || ((i % 5) == 1) || ((i % 5) == 3);
        PAT_DBL: m[i] = ((i % 14) < 2) || ((i % 14) == 4) || ((i % 14) == 5);
        default: m[i] = 1'b1;
      endcase
    end
    return m;
  endfunction

  localparam logic [PHASE_MOD-1:0] B1_MASK  = pattern_mask(PAT_B1);
  localparam logic [PHASE_MOD-1:0] B4_MASK  = pattern_mask(PAT_B4);
  localparam logic [PHASE_MOD-1:0] DBL_MASK = pattern_mask(PAT_DBL);

  function automatic logic pattern_on(pat_e p, logic [PHASE_W-1:0] ph);
    logic on;
    unique case (p)
      PAT_B1:  on = B1_MASK[ph];
      PAT_B4:  on = B4_MASK[ph];
      PAT_DBL: on = DBL_MASK[ph];
      default: on = 1'b1;
    endcase
    return on;
  endfunction

endpackage

[rtl/slpg_regs.sv]
// apb register block holding the channel enables
module slpg_regs
  import slpg_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (paddr[3:2])
        REG_RED_EN:   cfg_d.red_en   = pwdata[0];
        REG_GREEN_EN: cfg_d.green_en = pwdata[0];
        REG_BLUE_EN:  cfg_d.blue_en  = pwdata[0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RED_EN:   prdata = {{(PDATA_W-1){1'b0}}, cfg_q.red_en};
      REG_GREEN_EN: prdata = {{(PDATA_W-1){1'b0}}, cfg_q.green_en};
      REG_BLUE_EN:  prdata = {{(PDATA_W-1){1'b0}}, cfg_q.blue_en};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{red_en: 1'b1, green_en: 1'b1, blue_en: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/slpg_div.sv]
// shared restoring divider by a constant, four quotient bits per cycle
module slpg_div
  import slpg_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam int unsigned BITS_PER_CYCLE = 4;

  logic [TIME_W-1:0] num_q, num_n;
  logic [REM_W:0]    rem_q, rem_n;
  logic [QUO_W-1:0]  quo_q, quo_n;
  logic [REM_W-1:0]  dvs_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q, done_q;
  logic [REM_W:0]    trial;

  // dividend is left aligned; each bit shifts into the partial remainder
  always_comb begin
    num_n = num_q;
    rem_n = rem_q;
    quo_n = quo_q;
    trial = '0;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      trial = {rem_n[REM_W-1:0], num_n[TIME_W-1]};
      num_n = {num_n[TIME_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_n = trial - {1'b0, dvs_q};
        quo_n = {quo_n[QUO_W-2:0], 1'b1};
      end else begin
        rem_n = trial;
        quo_n = {quo_n[QUO_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= req_i.steps;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == STEP_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // divisor is held for the whole operation
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      num_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= num_n;
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;
  assign rsp_o.rem  = rem_q[REM_W-1:0];

endmodule

[rtl/status_led_pattern_generator.sv]
// top level: item sequencer, status state and result register
//
// Input channel (in_valid_i/in_ready_o) takes one beat per item: kind_i,
// status_code_i, now_us_i, ready_flag_i. Output channel (out_valid_o/
// out_ready_i) gives at most one beat per item with the red, green and blue
// write flags and duties; a duty whose write flag is low reads as zero.
// Set-status and flash-stamp beats finish in the accept cycle with no result.
// A ready-indicator beat with blue enabled goes straight to the emit step.
// A tick with red or green enabled and a flash, solid or blink pattern goes
// through the flash, check and emit steps; a tick with the pulse pattern runs
// five constant divisions on the shared divider (12 + 6 + 5 + 4 + 4 steps)
// between check and emit, where out_valid_o is raised. The divider is the pacing element.
// One item is worked on at a time; in_ready_o is high only when the sequencer
// is idle, and a finished result may wait in the output register while the
// next item is taken.
// If the receiver stalls, the result holds in the output register and a
// following item that has a result waits in the emit step until it drains.
// Reset sets all channels enabled, boot status, tick phase 0 and no flash.
// The channel enables live in the apb registers at byte addresses 0, 4, 8.
module status_led_pattern_generator
  import slpg_pkg::*;
#(
  parameter int unsigned FLASH_HOLD_US = 80000
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [2:0]         status_code_i,
  input  logic [TIME_W-1:0]  now_us_i,
  input  logic               ready_flag_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               red_write_o,
  output logic [DUTY_W-1:0]  red_duty_o,
  output logic               green_write_o,
  output logic [DUTY_W-1:0]  green_duty_o,
  output logic               blue_write_o,
  output logic [DUTY_W-1:0]  blue_duty_o
);

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  state_e  state_q, state_d;
  div_op_e op_q, op_d;

  logic [2:0]         status_q, status_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [TIME_W-1:0]  stamp_q, stamp_d;
  logic [TIME_W-1:0]  now_q, now_d;
  logic [TIME_W:0]    diff_q, diff_d;
  logic [DUTY_W-1:0]  bright_q, bright_d;
  logic [DUTY_W-1:0]  red_q, red_d;
  result_t            res_q, res_d;
  result_t            out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  logic               any_en;
  logic               rg_en;
  logic               out_free;
  logic               flash;
  logic               pulse;
  status_t            entry;
  logic [DUTY_W-1:0]  pat_r, pat_g;
  logic [10:0]        ms_phase;
  logic [9:0]         half;
  logic [17:0]        half_x255;
  logic [DUTY_W-1:0]  mul_a, mul_b;
  logic [15:0]        mul_p;

  slpg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  slpg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign any_en     = cfg.red_en | cfg.green_en | cfg.blue_en;
  assign rg_en      = cfg.red_en | cfg.green_en;
  assign out_free   = !out_valid_q || out_ready_i;

  assign entry = status_lookup(status_q);
  // borrow in bit 48 means the stamp lies in the future
  assign flash = (stamp_q != '0) &&
                 (diff_q[TIME_W] || (diff_q[TIME_W-1:0] < TIME_W'(FLASH_HOLD_US)));
  assign pulse = (entry.pat == PAT_BREATHE);

  always_comb begin
    if (flash || pattern_on(entry.pat, phase_q)) begin
      pat_r = entry.r;
      pat_g = entry.g;
    end else begin
      pat_r = '0;
      pat_g = '0;
    end
  end

  // triangle of the ms phase, then times 255
  assign ms_phase  = div_rsp.quo[10:0];
  assign half      = (ms_phase < HALF_PERIOD_MS) ? ms_phase[9:0]
                                                 : 10'(FULL_PERIOD_MS - ms_phase);
  assign half_x255 = {half, 8'b0} - {8'b0, half};

  assign mul_a = (op_q == OP_BRIGHT) ? entry.r : entry.g;
  assign mul_b = (op_q == OP_BRIGHT) ? div_rsp.quo[DUTY_W-1:0] : bright_q;
  assign mul_p = mul_a * mul_b;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (kind_i == KIND_READY && cfg.blue_en) begin
            state_d = ST_EMIT;
          end else if (kind_i == KIND_TICK && any_en) begin
            state_d = ST_FLASH;
          end
        end
      end
      ST_FLASH: state_d = ST_CHECK;
      ST_CHECK: begin
        if (!rg_en) begin
          state_d = ST_IDLE;
        end else if (!flash && pulse) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_DIV: begin
        if (div_rsp.done && op_q == OP_GREEN) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and divider requests
  always_comb begin
    status_d    = status_q;
    phase_d     = phase_q;
    stamp_d     = stamp_q;
    now_d       = now_q;
    diff_d      = diff_q;
    bright_d    = bright_q;
    red_d       = red_q;
    res_d       = res_q;
    op_d        = op_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    div_req     = '{start: 1'b0, dividend: '0, divisor: DIV_PERIOD_US,
                    steps: STEPS_PERIOD};

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (kind_i)
            KIND_STATUS: begin
              if (status_code_i < 3'(NUM_STATUS)) begin
                status_d = status_code_i;
              end
            end
            KIND_FLASH: stamp_d = now_us_i;
            KIND_TICK: begin
              if (any_en) begin
                phase_d = (phase_q == PHASE_W'(PHASE_MOD - 1)) ? '0 : phase_q + 1'b1;
                now_d   = now_us_i;
              end
            end
            KIND_READY: begin
              res_d            = '0;
              res_d.blue_write = 1'b1;
              res_d.blue_duty  = ready_flag_i ? 8'd255 : 8'd0;
            end
            default: res_d = res_q;
          endcase
        end
      end
      ST_FLASH: begin
        diff_d = {1'b0, now_q} - {1'b0, stamp_q};
      end
      ST_CHECK: begin
        res_d             = '0;
        res_d.red_write   = cfg.red_en;
        res_d.red_duty    = cfg.red_en ? pat_r : '0;
        res_d.green_write = cfg.green_en;
        res_d.green_duty  = cfg.green_en ? pat_g : '0;
        if (rg_en && !flash && pulse) begin
          op_d    = OP_PERIOD;
          div_req = '{start: 1'b1, dividend: now_q, divisor: DIV_PERIOD_US,
                      steps: STEPS_PERIOD};
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          unique case (op_q)
            OP_PERIOD: begin
              op_d    = OP_MS;
              div_req = '{start: 1'b1, dividend: {3'b0, div_rsp.rem, 24'b0},
                          divisor: DIV_THOUSAND, steps: STEPS_MS};
            end
            OP_MS: begin
              op_d    = OP_BRIGHT;
              div_req = '{start: 1'b1, dividend: {2'b0, half_x255, 28'b0},
                          divisor: DIV_THOUSAND, steps: STEPS_BRIGHT};
            end
            OP_BRIGHT: begin
              op_d     = OP_RED;
              bright_d = div_rsp.quo[DUTY_W-1:0];
              div_req  = '{start: 1'b1, dividend: {mul_p, 32'b0},
                           divisor: DIV_FULL, steps: STEPS_SCALE};
            end
            OP_RED: begin
              op_d    = OP_GREEN;
              red_d   = div_rsp.quo[DUTY_W-1:0];
              div_req = '{start: 1'b1, dividend: {mul_p, 32'b0},
                          divisor: DIV_FULL, steps: STEPS_SCALE};
            end
            OP_GREEN: begin
              res_d.red_duty   = cfg.red_en ? red_q : '0;
              res_d.green_duty = cfg.green_en ? div_rsp.quo[DUTY_W-1:0] : '0;
            end
            default: op_d = op_q;
          endcase
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: op_d = op_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_PERIOD;
      status_q    <= '0;
      phase_q     <= '0;
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      status_q    <= status_d;
      phase_q     <= phase_d;
      stamp_q     <= stamp_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    now_q    <= now_d;
    diff_q   <= diff_d;
    bright_q <= bright_d;
    red_q    <= red_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign red_write_o   = out_q.red_write;
  assign red_duty_o    = out_q.red_duty;
  assign green_write_o = out_q.green_write;
  assign green_duty_o  = out_q.green_duty;
  assign blue_write_o  = out_q.blue_write;
  assign blue_duty_o   = out_q.blue_duty;

endmodule
